// File: rtl/asmc_pkg.sv
// Shared types and constants of the swept box clip block.
// No dependencies; every other file of the block but asmc_ram uses this package.
package asmc_pkg;

  // Q16.16 signed coordinate
  typedef logic signed [31:0] coord_t;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Move axis codes; the fourth code moves along nothing
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TOUCH = 2'd2;

  // Register reset values (0.005, 0.002 and 0.5 in Q16.16)
  localparam logic [15:0] OVERLAP_RST    = 16'd328;
  localparam logic [15:0] TOUCH_RST      = 16'd131;
  localparam logic [16:0] DOWN_TOUCH_RST = 17'd32768;

  // Input item
  typedef struct packed {
    logic       cmd;
    logic [6:0] entry_index;
    logic       entry_active;
    coord_t     low_x;
    coord_t     low_y;
    coord_t     low_z;
    coord_t     high_x;
    coord_t     high_y;
    coord_t     high_z;
    logic [1:0] axis;
    coord_t     move_delta;
  } in_item_t;

  // Result item
  typedef struct packed {
    coord_t clipped_delta;
    logic   was_clipped;
  } out_item_t;

  // Configuration write
  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_item_t;

  // One obstacle entry as kept in the RAM
  typedef struct packed {
    logic   active;
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } entry_t;

  // Query context, fixed for the whole walk
  typedef struct packed {
    logic [1:0]  axis;
    logic [6:0]  skip;
    coord_t      mv_lo;   // moving box on the move axis
    coord_t      mv_hi;
    coord_t      s_lo;    // first side axis
    coord_t      s_hi;
    coord_t      t_lo;    // second side axis
    coord_t      t_hi;
    logic [15:0] om;
    logic [15:0] tm;
    logic [16:0] tn;
  } qctx_t;

  // Per-entry verdict handed to the delta update
  typedef struct packed {
    logic   vld;
    logic   usable;
    logic   pos_hit;
    logic   neg_hit;
    coord_t cpos;
    coord_t cneg;
  } eval_t;

  // Control states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_DONE
  } state_e;

endpackage

// File: rtl/asmc_if.sv
// Handshake channels of the swept box clip block: query/write items,
// result items and configuration writes. Depends on asmc_pkg.
interface asmc_req_if;
  logic                valid;
  logic                ready;
  asmc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asmc_rsp_if;
  logic                valid;
  logic                ready;
  asmc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asmc_cfg_if;
  logic                valid;
  logic                ready;
  asmc_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/asmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module asmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/asmc_entry_eval.sv
// Per-entry test stage: side-axis overlap, face tests and saturated clip
// distances for one obstacle read from the RAM. Depends on asmc_pkg.
module asmc_entry_eval #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned IDX_W       = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_vld_i,
  input  logic [IDX_W-1:0]   rd_idx_i,
  input  asmc_pkg::entry_t   entry_i,
  input  asmc_pkg::qctx_t    ctx_i,
  output asmc_pkg::eval_t    eval_o
);
  import asmc_pkg::*;

  localparam int unsigned CMP_W = (IDX_W > 7) ? IDX_W : 7;
  // clip saturates to the narrower of the coordinate and output ranges
  localparam int unsigned SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (SAT_W - 1)) - 33'sd1;
  localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

  function automatic coord_t sat_clip(input logic signed [32:0] v);
    coord_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  coord_t oa_lo, oa_hi, os_lo, os_hi, ot_lo, ot_hi;
  logic   axis_ok;

  // obstacle coordinates rotated into move / side order
  always_comb begin
    axis_ok = 1'b1;
    case (ctx_i.axis)
      AXIS_X: begin
        oa_lo = entry_i.lo_x; oa_hi = entry_i.hi_x;
        os_lo = entry_i.lo_y; os_hi = entry_i.hi_y;
        ot_lo = entry_i.lo_z; ot_hi = entry_i.hi_z;
      end
      AXIS_Y: begin
        oa_lo = entry_i.lo_y; oa_hi = entry_i.hi_y;
        os_lo = entry_i.lo_z; os_hi = entry_i.hi_z;
        ot_lo = entry_i.lo_x; ot_hi = entry_i.hi_x;
      end
      AXIS_Z: begin
        oa_lo = entry_i.lo_z; oa_hi = entry_i.hi_z;
        os_lo = entry_i.lo_x; os_hi = entry_i.hi_x;
        ot_lo = entry_i.lo_y; ot_hi = entry_i.hi_y;
      end
      default: begin
        axis_ok = 1'b0;
        oa_lo = entry_i.lo_x; oa_hi = entry_i.hi_x;
        os_lo = entry_i.lo_y; os_hi = entry_i.hi_y;
        ot_lo = entry_i.lo_z; ot_hi = entry_i.hi_z;
      end
    endcase
  end

  // exact margin sums, 34-bit signed
  logic signed [33:0] om_w, tm_w, tn_w;
  logic signed [33:0] s_lo_p, s_hi_m, t_lo_p, t_hi_m, oa_lo_p, oa_hi_m;
  logic signed [32:0] cpos_raw, cneg_raw;
  logic               side_ok, not_skip;

  assign om_w    = $signed(34'(ctx_i.om));
  assign tm_w    = $signed(34'(ctx_i.tm));
  assign tn_w    = $signed(34'(ctx_i.tn));
  assign s_lo_p  = 34'(ctx_i.s_lo) + om_w;
  assign s_hi_m  = 34'(ctx_i.s_hi) - om_w;
  assign t_lo_p  = 34'(ctx_i.t_lo) + om_w;
  assign t_hi_m  = 34'(ctx_i.t_hi) - om_w;
  assign oa_lo_p = 34'(oa_lo) + tm_w;
  assign oa_hi_m = 34'(oa_hi) - tn_w;

  assign side_ok = (s_lo_p < 34'(os_hi)) && (s_hi_m > 34'(os_lo)) &&
                   (t_lo_p < 34'(ot_hi)) && (t_hi_m > 34'(ot_lo));
  assign not_skip = CMP_W'(rd_idx_i) != CMP_W'(ctx_i.skip);

  // distances to the near and far faces
  assign cpos_raw = 33'(oa_lo) - 33'(ctx_i.mv_hi);
  assign cneg_raw = 33'(oa_hi) - 33'(ctx_i.mv_lo);

  logic vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= rd_vld_i;
    end
  end

  logic   usable_q, pos_hit_q, neg_hit_q;
  coord_t cpos_q, cneg_q;

  always_ff @(posedge clk_i) begin
    usable_q  <= entry_i.active && not_skip && axis_ok && side_ok;
    pos_hit_q <= 34'(ctx_i.mv_hi) <= oa_lo_p;
    neg_hit_q <= 34'(ctx_i.mv_lo) >= oa_hi_m;
    cpos_q    <= sat_clip(cpos_raw);
    cneg_q    <= sat_clip(cneg_raw);
  end

  assign eval_o.vld     = vld_q;
  assign eval_o.usable  = usable_q;
  assign eval_o.pos_hit = pos_hit_q;
  assign eval_o.neg_hit = neg_hit_q;
  assign eval_o.cpos    = cpos_q;
  assign eval_o.cneg    = cneg_q;

endmodule

// File: rtl/aabb_swept_move_clip.sv
// Top level of the swept box clip block: obstacle RAM, walk control,
// delta update and result register. Depends on asmc_pkg, asmc_if,
// asmc_ram and asmc_entry_eval.
//
// After reset the block clears the active bit of every entry in the obstacle
// RAM and takes no item until that pass is done (configuration writes are taken
// at all times). A write item stores its entry straight into the RAM if its
// index lies inside the table. A query item reads every entry in index order
// through the RAM's single read port, one entry per cycle, and then passes the
// RAM read and test stages, a flush of those stages and the result load. One
// query is in flight at a time; the result waits in an output register, so the
// next item can be taken while it is still unclaimed.
module aabb_swept_move_clip #(
  parameter int unsigned NUM_ENTRIES = 64,
  parameter int unsigned COORD_WIDTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  asmc_req_if.sink   req_i,
  asmc_rsp_if.source rsp_o,
  asmc_cfg_if.sink   cfg_i
);
  import asmc_pkg::*;

  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_ENTRIES - 1);
  localparam coord_t ZERO = 32'sd0;

  // ---------------- configuration registers ----------------
  logic [15:0] om_q, tm_q;
  logic [16:0] tdn_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      om_q  <= OVERLAP_RST;
      tm_q  <= TOUCH_RST;
      tdn_q <= DOWN_TOUCH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_OVERLAP:    om_q  <= cfg_i.data.value[15:0];
        CFG_TOUCH:      tm_q  <= cfg_i.data.value[15:0];
        CFG_DOWN_TOUCH: tdn_q <= cfg_i.data.value[16:0];
        default: ;
      endcase
    end
  end

  // ---------------- query context from the incoming item ----------------
  qctx_t ctx_d, ctx_q;

  always_comb begin
    ctx_d.axis = req_i.data.axis;
    ctx_d.skip = req_i.data.entry_index;
    ctx_d.om   = om_q;
    ctx_d.tm   = tm_q;
    ctx_d.tn   = {1'b0, tm_q};
    case (req_i.data.axis)
      AXIS_X: begin
        ctx_d.mv_lo = req_i.data.low_x; ctx_d.mv_hi = req_i.data.high_x;
        ctx_d.s_lo  = req_i.data.low_y; ctx_d.s_hi  = req_i.data.high_y;
        ctx_d.t_lo  = req_i.data.low_z; ctx_d.t_hi  = req_i.data.high_z;
      end
      AXIS_Y: begin
        ctx_d.tn    = tdn_q;
        ctx_d.mv_lo = req_i.data.low_y; ctx_d.mv_hi = req_i.data.high_y;
        ctx_d.s_lo  = req_i.data.low_z; ctx_d.s_hi  = req_i.data.high_z;
        ctx_d.t_lo  = req_i.data.low_x; ctx_d.t_hi  = req_i.data.high_x;
      end
      AXIS_Z: begin
        ctx_d.mv_lo = req_i.data.low_z; ctx_d.mv_hi = req_i.data.high_z;
        ctx_d.s_lo  = req_i.data.low_x; ctx_d.s_hi  = req_i.data.high_x;
        ctx_d.t_lo  = req_i.data.low_y; ctx_d.t_hi  = req_i.data.high_y;
      end
      default: begin
        // no move axis: the test stage rejects every entry
        ctx_d.mv_lo = req_i.data.low_x; ctx_d.mv_hi = req_i.data.high_x;
        ctx_d.s_lo  = req_i.data.low_y; ctx_d.s_hi  = req_i.data.high_y;
        ctx_d.t_lo  = req_i.data.low_z; ctx_d.t_hi  = req_i.data.high_z;
      end
    endcase
  end

  // ---------------- control ----------------
  state_e           state_d, state_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             ram_we, ram_re, load_ctx, out_load, rd_vld_q;
  logic [IDX_W-1:0] ram_waddr, rd_idx_q;
  entry_t           ram_wdata, ram_rdata;
  eval_t            ev;
  logic             req_acc, in_range;

  assign req_acc  = req_i.valid && req_i.ready;
  assign in_range = 32'(req_i.data.entry_index) < NUM_ENTRIES;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = IDX_W'(req_i.data.entry_index);
    ram_wdata   = '0;
    load_ctx    = 1'b0;
    out_load    = 1'b0;
    req_i.ready = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[IDX_W-1:0];
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        req_i.ready      = 1'b1;
        ram_wdata.active = req_i.data.entry_active;
        ram_wdata.lo_x   = req_i.data.low_x;
        ram_wdata.lo_y   = req_i.data.low_y;
        ram_wdata.lo_z   = req_i.data.low_z;
        ram_wdata.hi_x   = req_i.data.high_x;
        ram_wdata.hi_y   = req_i.data.high_y;
        ram_wdata.hi_z   = req_i.data.high_z;
        if (req_acc) begin
          if (req_i.data.cmd == CMD_QUERY) begin
            load_ctx = 1'b1;
            cnt_d    = '0;
            state_d  = ST_WALK;
          end else begin
            ram_we = in_range;
          end
        end
      end
      ST_WALK: begin
        ram_re = 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_FLUSH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FLUSH: begin
        // wait for the last entry to leave the read and test stages
        if (!rd_vld_q && !ev.vld) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_o.valid || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= ram_re;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IDX_W-1:0];
    if (load_ctx) begin
      ctx_q <= ctx_d;
    end
  end

  // ---------------- obstacle RAM and test stage ----------------
  asmc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  asmc_entry_eval #(
    .COORD_WIDTH (COORD_WIDTH),
    .IDX_W       (IDX_W)
  ) u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_vld_i (rd_vld_q),
    .rd_idx_i (rd_idx_q),
    .entry_i  (ram_rdata),
    .ctx_i    (ctx_q),
    .eval_o   (ev)
  );

  // ---------------- delta update ----------------
  coord_t d_q, d_min, d_max, req_delta_q;

  // shorten a forward move first, then a backward one with the new delta
  always_comb begin
    d_min = d_q;
    if (ev.usable && ev.pos_hit && (d_q > ZERO) && (ev.cpos < d_q)) begin
      d_min = ev.cpos;
    end
    d_max = d_min;
    if (ev.usable && ev.neg_hit && (d_min < ZERO) && (ev.cneg > d_min)) begin
      d_max = ev.cneg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ctx) begin
      d_q         <= req_i.data.move_delta;
      req_delta_q <= req_i.data.move_delta;
    end else if (ev.vld) begin
      d_q <= d_max;
    end
  end

  // ---------------- result register ----------------
  logic      out_vld_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.clipped_delta <= d_q;
      out_q.was_clipped   <= d_q != req_delta_q;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

`ifndef ASSERT_OFF
  // the RAM is never written while a walk is reading it
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("obstacle RAM written during a walk");

  // test results only arrive while a query is being walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.vld |-> (state_q == ST_WALK || state_q == ST_FLUSH))
    else $error("entry verdict outside a walk");

  // a new result only appears after the walk has fully drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_DONE && !$past(ev.vld))
    else $error("result raised before the walk drained");

  // a finished query holds while an unclaimed result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_vld_q && !rsp_o.ready) |=> state_q == ST_DONE)
    else $error("pending result overwritten");
`endif

endmodule

// File: sim/aabb_swept_move_clip_tb.sv
// Self-checking testbench for aabb_swept_move_clip: obstacle writes and swept
// clip queries against a predictor of its own. Depends on asmc_pkg, asmc_if and the DUT.
// Runs directed corner items, then random scenes under several margin settings.
module aabb_swept_move_clip_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asmc_pkg::*;

  localparam int ENTRIES = 64;
  localparam int ONE = 65536;                 // 1.0 in Q16.16
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 234;
  localparam int SCENE_MAX = 6;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = ENTRIES + 16;
  localparam int SETTLE_LIMIT = 50000;
  localparam logic [6:0] SKIP_NONE = 7'd64;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index

  logic clk_i;
  logic rst_ni;

  asmc_req_if req_if ();
  asmc_rsp_if rsp_if ();
  asmc_cfg_if cfg_if ();

  aabb_swept_move_clip #(
    .NUM_ENTRIES(ENTRIES),
    .COORD_WIDTH(32)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // Shadow of the obstacle table and margin registers
  coord_t      obst_lo [ENTRIES][3];
  coord_t      obst_hi [ENTRIES][3];
  logic        obst_on [ENTRIES];
  logic [15:0] overlap_q;
  logic [15:0] touch_q;
  logic [16:0] down_q;

  in_item_t  pending_items [$];
  out_item_t expected_clips [$];

  int   n_items, n_writes, n_queries, n_results, n_clipped, mismatches;
  logic quiet;
  int   req_gap, rsp_hold;
  logic req_fire, rsp_fire;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("aabb_swept_move_clip regression: fail");
    $finish;
  end

  // Saturate a clip distance to the 32-bit coordinate range
  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Expected final delta of one query against the current table
  function automatic out_item_t clip_move(input in_item_t q);
    longint    lo [3], hi [3], olo [3], ohi [3];
    longint    req, d, om, tm, tn, c;
    int        a, s, t, i, j;
    out_item_t r;
    lo[0] = $signed(q.low_x);
    lo[1] = $signed(q.low_y);
    lo[2] = $signed(q.low_z);
    hi[0] = $signed(q.high_x);
    hi[1] = $signed(q.high_y);
    hi[2] = $signed(q.high_z);
    req = $signed(q.move_delta);
    d = req;
    om = overlap_q;
    tm = touch_q;
    tn = (q.axis == AXIS_Y) ? longint'(down_q) : longint'(touch_q);
    if (q.axis != AXIS_NONE) begin
      a = q.axis;
      s = (a + 1) % 3;
      t = (a + 2) % 3;
      for (i = 0; i < ENTRIES; i++) begin
        if (i == q.entry_index || !obst_on[i]) continue;
        for (j = 0; j < 3; j++) begin
          olo[j] = obst_lo[i][j];
          ohi[j] = obst_hi[i][j];
        end
        // side axes must overlap by more than the shrink margin
        if (!(lo[s] + om < ohi[s] && hi[s] - om > olo[s] &&
              lo[t] + om < ohi[t] && hi[t] - om > olo[t])) continue;
        if (d > 0 && hi[a] <= olo[a] + tm) begin
          c = sat32(olo[a] - hi[a]);
          if (d > c) d = c;
        end
        if (d < 0 && lo[a] >= ohi[a] - tn) begin
          c = sat32(ohi[a] - lo[a]);
          if (d < c) d = c;
        end
      end
    end
    r.clipped_delta = coord_t'(d);
    r.was_clipped = (d != req);
    return r;
  endfunction

  function automatic int idle_draw();
    if ($urandom_range(0, 49) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  // Acceptance: track the table, queue predictions, check results
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    req_fire <= req_if.valid && req_if.ready;
    rsp_fire <= rsp_if.valid && rsp_if.ready;
    if (req_if.valid && req_if.ready) begin
      if (req_if.data.cmd == CMD_WRITE) begin
        if (req_if.data.entry_index < ENTRIES) begin
          obst_lo[req_if.data.entry_index][0] = req_if.data.low_x;
          obst_lo[req_if.data.entry_index][1] = req_if.data.low_y;
          obst_lo[req_if.data.entry_index][2] = req_if.data.low_z;
          obst_hi[req_if.data.entry_index][0] = req_if.data.high_x;
          obst_hi[req_if.data.entry_index][1] = req_if.data.high_y;
          obst_hi[req_if.data.entry_index][2] = req_if.data.high_z;
          obst_on[req_if.data.entry_index] = req_if.data.entry_active;
        end
      end else begin
        expected_clips.push_back(clip_move(req_if.data));
      end
    end
    if (rsp_if.valid && rsp_if.ready) begin
      n_results++;
      if (rsp_if.data.was_clipped) n_clipped++;
      if (expected_clips.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with none pending: delta %h clipped %b",
                   rsp_if.data.clipped_delta, rsp_if.data.was_clipped);
      end else begin
        want = expected_clips.pop_front();
        if (rsp_if.data.clipped_delta !== want.clipped_delta ||
            rsp_if.data.was_clipped !== want.was_clipped) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected delta %h clipped %b, got delta %h clipped %b",
                     n_results, want.clipped_delta, want.was_clipped,
                     rsp_if.data.clipped_delta, rsp_if.data.was_clipped);
        end
      end
    end
  end

  // Item driver: next item after the drawn gap once the current one is taken
  always @(negedge clk_i) begin
    if (!req_if.valid || req_fire) begin
      if (req_gap != 0) begin
        req_if.valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (pending_items.size() != 0) begin
        req_if.valid <= 1'b1;
        req_if.data <= pending_items.pop_front();
        req_gap <= idle_draw();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result side: stall a drawn number of cycles after each taken result
  always @(negedge clk_i) begin : result_stall
    int n;
    if (rsp_fire) begin
      n = idle_draw();
      rsp_hold <= n;
      rsp_if.ready <= (n == 0);
    end else if (rsp_hold != 0) begin
      rsp_hold <= rsp_hold - 1;
      rsp_if.ready <= (rsp_hold == 1);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= {idx, value};
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_OVERLAP:    overlap_q = value[15:0];
      CFG_TOUCH:      touch_q = value[15:0];
      CFG_DOWN_TOUCH: down_q = value[16:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic post(input in_item_t it);
    pending_items.push_back(it);
    if (it.cmd == CMD_QUERY) n_queries++;
    else if (it.entry_index < ENTRIES) n_writes++;
    // writes past the table end are dropped and not counted
    if (it.cmd == CMD_QUERY || it.entry_index < ENTRIES) n_items++;
  endtask

  // Wait for every item to be taken and every result to come, then let
  // any trailing write finish
  task automatic settle();
    int guard;
    guard = 0;
    while ((pending_items.size() != 0 || req_if.valid || expected_clips.size() != 0) &&
           guard < SETTLE_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_item_t item_of(input logic c, input logic [6:0] idx,
                                       input logic act, input coord_t lx, ly, lz,
                                       input coord_t hx, hy, hz,
                                       input logic [1:0] ax, input coord_t dl);
    in_item_t it;
    it.cmd = c;
    it.entry_index = idx;
    it.entry_active = act;
    {it.low_x, it.low_y, it.low_z} = {lx, ly, lz};
    {it.high_x, it.high_y, it.high_z} = {hx, hy, hz};
    it.axis = ax;
    it.move_delta = dl;
    return it;
  endfunction

  // Random geometry helpers, in Q16.16
  function automatic coord_t scene_pt(input coord_t org);
    return org + (int'($urandom_range(0, 64)) - 32) * (ONE / 4) +
           int'($urandom_range(0, 600)) - 300;
  endfunction

  function automatic coord_t box_size();
    if ($urandom_range(0, 19) == 0) return -int'($urandom_range(0, 2 * ONE));  // inverted
    return int'($urandom_range(1, 16)) * (ONE / 4) + int'($urandom_range(0, 600)) - 300;
  endfunction

  // Distance from the box to the face it approaches; negative means inside
  function automatic coord_t gap();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return int'($urandom_range(0, 600)) - 300;
      2: return int'($urandom_range(0, 2 * ONE)) - ONE;
      3: return -int'(touch_q) + int'($urandom_range(0, 4)) - 2;
      4: return -int'(down_q) + int'($urandom_range(0, 4)) - 2;
      default: return int'($urandom_range(0, 12)) * (ONE / 4);
    endcase
  endfunction

  function automatic coord_t move_amount(input logic up);
    coord_t m;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return up ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return $urandom;
      3: m = $urandom_range(0, 1000);
      default: m = $urandom_range(0, 16 * ONE);
    endcase
    return up ? m : -m;
  endfunction

  // Random scenes: a few obstacles around an origin, then queries mostly aimed at them
  task automatic run_scenes(input int upto);
    coord_t     org, sz;
    coord_t     ob_lo [SCENE_MAX][3];
    coord_t     ob_hi [SCENE_MAX][3];
    logic [6:0] ob_idx [SCENE_MAX];
    coord_t     bl [3], bh [3];
    in_item_t   it;
    logic       up;
    int         nobs, nq, k, j, g, qn;
    while (n_items < upto) begin
      case ($urandom_range(0, 9))
        0: org = 32'h7FF0_0000;
        1: org = 32'h800F_0000;
        default: org = (int'($urandom_range(0, 4000)) - 2000) * ONE;
      endcase

      // obstacle writes, a few inactive or past the table end
      nobs = $urandom_range(1, SCENE_MAX);
      for (k = 0; k < nobs; k++) begin
        for (j = 0; j < 3; j++) begin
          ob_lo[k][j] = scene_pt(org);
          ob_hi[k][j] = ob_lo[k][j] + box_size();
        end
        ob_idx[k] = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(64, 127))
                                                 : 7'($urandom_range(0, 63));
        post(item_of(CMD_WRITE, ob_idx[k], $urandom_range(0, 7) != 0,
                     ob_lo[k][0], ob_lo[k][1], ob_lo[k][2],
                     ob_hi[k][0], ob_hi[k][1], ob_hi[k][2], 2'($urandom), $urandom));
      end

      // queries
      nq = $urandom_range(1, 8);
      for (qn = 0; qn < nq; qn++) begin
        it.cmd = CMD_QUERY;
        it.entry_active = $urandom;
        it.axis = ($urandom_range(0, 11) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
        g = (it.axis == AXIS_NONE) ? $urandom_range(0, 2) : it.axis;
        k = $urandom_range(0, nobs - 1);
        case ($urandom_range(0, 3))
          0: it.entry_index = 7'($urandom);
          1: it.entry_index = ob_idx[k];
          default: it.entry_index = SKIP_NONE;
        endcase
        if ($urandom_range(0, 3) != 0) begin
          // aimed at one obstacle: sides near its extent, move axis at a face
          for (j = 0; j < 3; j++) begin
            if (j == g) continue;
            case ($urandom_range(0, 5))
              0: begin
                bl[j] = ob_hi[k][j] - overlap_q + int'($urandom_range(0, 4)) - 2;
                bh[j] = bl[j] + box_size();
              end
              1: begin
                bh[j] = ob_lo[k][j] + overlap_q + int'($urandom_range(0, 4)) - 2;
                bl[j] = bh[j] - box_size();
              end
              default: begin
                bl[j] = ob_lo[k][j] + int'($urandom_range(0, ONE)) - ONE / 2;
                bh[j] = ob_hi[k][j] + int'($urandom_range(0, ONE)) - ONE / 2;
              end
            endcase
          end
          sz = box_size();
          up = $urandom_range(0, 1);
          if (up) begin
            bh[g] = ob_lo[k][g] - gap();
            bl[g] = bh[g] - sz;
          end else begin
            bl[g] = ob_hi[k][g] + gap();
            bh[g] = bl[g] + sz;
          end
          if ($urandom_range(0, 4) == 0) up = !up;
        end else begin
          for (j = 0; j < 3; j++) begin
            bl[j] = scene_pt(org);
            bh[j] = bl[j] + box_size();
          end
          up = $urandom_range(0, 1);
        end
        {it.low_x, it.low_y, it.low_z} = {bl[0], bl[1], bl[2]};
        {it.high_x, it.high_y, it.high_z} = {bh[0], bh[1], bh[2]};
        it.move_delta = move_amount(up);
        post(it);
      end

      // occasional item with every field random
      if ($urandom_range(0, 2) == 0) begin
        post(item_of($urandom, 7'($urandom), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, 2'($urandom), $urandom));
      end
    end
  endtask

  initial begin : main
    int phase, i;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    req_fire = 1'b0;
    rsp_fire = 1'b0;
    req_gap = 0;
    rsp_hold = 0;
    quiet = 1'b0;
    n_items = 0;
    n_writes = 0;
    n_queries = 0;
    n_results = 0;
    n_clipped = 0;
    mismatches = 0;
    overlap_q = OVERLAP_RST;
    touch_q = TOUCH_RST;
    down_q = DOWN_TOUCH_RST;
    for (i = 0; i < ENTRIES; i++) obst_on[i] = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (phase = 0; phase < PHASES; phase++) begin
      quiet = (phase == 2);
      case (phase)
        0: begin
          // directed corners under reset margins
          // empty table clips nothing
          post(item_of(CMD_QUERY, SKIP_NONE, 0, 0, 0, 0, ONE, ONE, ONE, AXIS_X, 20 * ONE));
          // wall ahead on +x, floor below, an inactive block on +z
          post(item_of(CMD_WRITE, 0, 1, 10 * ONE, -ONE, -ONE, 12 * ONE, ONE, ONE,
                       AXIS_X, 0));
          post(item_of(CMD_WRITE, 63, 1, -5 * ONE, -3 * ONE, -5 * ONE,
                       5 * ONE, -2 * ONE, 5 * ONE, AXIS_X, 0));
          post(item_of(CMD_WRITE, 5, 0, -ONE, -ONE, 4 * ONE, ONE, ONE, 6 * ONE, AXIS_X, 0));
          // writes past the table end must not land anywhere
          post(item_of(CMD_WRITE, 64, 1, 2 * ONE, -ONE, -ONE, 3 * ONE, ONE, ONE, AXIS_X, 0));
          post(item_of(CMD_WRITE, 127, 1, 2 * ONE, -ONE, -ONE, 3 * ONE, ONE, ONE, AXIS_X, 0));
          // +x into the wall, then skipping it, then a skip past the table end
          post(item_of(CMD_QUERY, SKIP_NONE, 0, 0, -ONE / 2, -ONE / 2, ONE, ONE / 2, ONE / 2,
                       AXIS_X, 20 * ONE));
          post(item_of(CMD_QUERY, 0, 0, 0, -ONE / 2, -ONE / 2, ONE, ONE / 2, ONE / 2,
                       AXIS_X, 20 * ONE));
          post(item_of(CMD_QUERY, 127, 0, 0, -ONE / 2, -ONE / 2, ONE, ONE / 2, ONE / 2,
                       AXIS_X, 20 * ONE));
          // falling onto the floor within the down margin, and from inside it
          post(item_of(CMD_QUERY, SKIP_NONE, 0, -ONE / 2, -17 * ONE / 10, -ONE / 2,
                       ONE / 2, -7 * ONE / 10, ONE / 2, AXIS_Y, -10 * ONE));
          post(item_of(CMD_QUERY, SKIP_NONE, 0, -ONE / 2, -23 * ONE / 10, -ONE / 2,
                       ONE / 2, -13 * ONE / 10, ONE / 2, AXIS_Y, -10 * ONE));
          // rising into the floor from below
          post(item_of(CMD_QUERY, SKIP_NONE, 0, -ONE / 2, -4 * ONE, -ONE / 2,
                       ONE / 2, -32 * ONE / 10, ONE / 2, AXIS_Y, 10 * ONE));
          // inactive entry does not block; zero move
          post(item_of(CMD_QUERY, SKIP_NONE, 0, -ONE / 2, -ONE / 2, 0, ONE / 2, ONE / 2, ONE,
                       AXIS_Z, 10 * ONE));
          post(item_of(CMD_QUERY, SKIP_NONE, 0, -ONE / 2, -ONE / 2, 0, ONE / 2, ONE / 2, ONE,
                       AXIS_Z, 0));
          // no move axis
          post(item_of(CMD_QUERY, SKIP_NONE, 0, 0, -ONE / 2, -ONE / 2, ONE, ONE / 2, ONE / 2,
                       AXIS_NONE, 7 * ONE));
          // -x back onto the wall's far face
          post(item_of(CMD_QUERY, SKIP_NONE, 0, 13 * ONE, -ONE / 2, -ONE / 2,
                       14 * ONE, ONE / 2, ONE / 2, AXIS_X, -20 * ONE));
          // wall at the top of the range, approached from both ends: saturating
          post(item_of(CMD_WRITE, 1, 1, 32'sh7FFF_0000, -ONE, -ONE, 32'sh7FFF_FFFF, ONE, ONE,
                       AXIS_X, 0));
          post(item_of(CMD_QUERY, SKIP_NONE, 0, 32'sh8000_0000, -ONE / 2, -ONE / 2,
                       32'sh8000_0000, ONE / 2, ONE / 2, AXIS_X, 32'sh7FFF_FFFF));
          post(item_of(CMD_QUERY, SKIP_NONE, 0, 32'sh7FFF_FFFF, -ONE / 2, -ONE / 2,
                       32'sh7FFF_FFFF, ONE / 2, ONE / 2, AXIS_X, 32'sh8000_0000));
          // inverted side extent used as given
          post(item_of(CMD_QUERY, SKIP_NONE, 0, 0, ONE / 2, -ONE / 2, ONE, -ONE / 2, ONE / 2,
                       AXIS_X, 20 * ONE));
          // all-ones and all-zero fields
          post(item_of(CMD_QUERY, 7'h7F, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, AXIS_NONE, 32'hFFFF_FFFF));
          post(item_of(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
          post(item_of(CMD_WRITE, 7'h7F, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, AXIS_NONE, 32'hFFFF_FFFF));
        end
        1: begin
          cfg_write(CFG_OVERLAP, 32'd0);
          cfg_write(CFG_TOUCH, 32'd0);
          cfg_write(CFG_DOWN_TOUCH, 32'd0);
          cfg_write(CFG_SPARE, $urandom);
        end
        2: begin
          cfg_write(CFG_OVERLAP, 32'hFFFF_FFFF);
          cfg_write(CFG_TOUCH, 32'hFFFF_FFFF);
          cfg_write(CFG_DOWN_TOUCH, 32'hFFFF_FFFF);
        end
        3: begin
          cfg_write(CFG_OVERLAP, $urandom);
          cfg_write(CFG_TOUCH, $urandom);
          cfg_write(CFG_DOWN_TOUCH, $urandom);
        end
        4: begin
          cfg_write(CFG_OVERLAP, $urandom_range(0, 2000));
          cfg_write(CFG_TOUCH, $urandom_range(0, 2000));
          cfg_write(CFG_DOWN_TOUCH, $urandom_range(0, 131071));
        end
        default: begin
          cfg_write(CFG_OVERLAP, OVERLAP_RST);
          cfg_write(CFG_TOUCH, TOUCH_RST);
          cfg_write(CFG_DOWN_TOUCH, DOWN_TOUCH_RST);
        end
      endcase
      run_scenes((phase + 1) * PHASE_ITEMS);
      settle();
    end

    if (expected_clips.size() != 0) begin
      $display("%0d expected results never arrived", expected_clips.size());
      mismatches += expected_clips.size();
    end
    $display("covered %0d table writes and %0d clip queries over %0d margin settings",
             n_writes, n_queries, PHASES);
    $display("%0d results checked, %0d clipped, %0d mismatches",
             n_results, n_clipped, mismatches);
    if (mismatches == 0) begin
      $display("aabb_swept_move_clip regression: pass");
    end else begin
      $display("aabb_swept_move_clip regression: fail");
    end
    $finish;
  end

endmodule

// File: aabb_swept_move_clip.f
rtl/asmc_pkg.sv
rtl/asmc_if.sv
rtl/asmc_ram.sv
rtl/asmc_entry_eval.sv
rtl/aabb_swept_move_clip.sv
sim/aabb_swept_move_clip_tb.sv
